// File: sv/vector_fir_window_filter_core_macros.svh
// Assertion macros shared by the FIR window filter checks
`ifndef VECTOR_FIR_WINDOW_FILTER_CORE_MACROS_SVH
`define VECTOR_FIR_WINDOW_FILTER_CORE_MACROS_SVH

// Check cons in the same cycle as ante
`define VFWF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define VFWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/vfwf_pkg.sv
// Shared constants and types of the three-axis FIR window filter
package vfwf_pkg;

  localparam int DEF_MAX_TAPS     = 256;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_COEF_WIDTH   = 16;

  localparam int TAPC_W = 9;   // tap count register
  localparam int TIDX_W = 8;   // coefficient slot field of a load request
  localparam int CMD_W  = 2;
  localparam int AXES   = 3;

  localparam logic [TAPC_W-1:0] TAP_COUNT_RST = 9'd256;

  localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic clear;  // zero the accumulators for a new sample
    logic en;     // ring and coefficient read data valid this cycle
  } vfwf_mac_ctl_t;

endpackage

// File: sv/vfwf_in_if.sv
// Request channel of the FIR window filter
interface vfwf_in_if
  import vfwf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = DEF_COEF_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic [CMD_W-1:0]               command;
  logic signed [SAMPLE_WIDTH-1:0] sample_x;
  logic signed [SAMPLE_WIDTH-1:0] sample_y;
  logic signed [SAMPLE_WIDTH-1:0] sample_z;
  logic [TIDX_W-1:0]              tap_index;
  logic signed [COEF_WIDTH-1:0]   coef_value;

  modport source (
    output valid, command, sample_x, sample_y, sample_z, tap_index, coef_value,
    input  ready
  );
  modport sink (
    input  valid, command, sample_x, sample_y, sample_z, tap_index, coef_value,
    output ready
  );
endinterface

// File: sv/vfwf_out_if.sv
// Result channel of the FIR window filter
interface vfwf_out_if
  import vfwf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filt_x;
  logic signed [SAMPLE_WIDTH-1:0] filt_y;
  logic signed [SAMPLE_WIDTH-1:0] filt_z;
  logic                           saturated;

  modport source (
    output valid, filt_x, filt_y, filt_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, filt_x, filt_y, filt_z, saturated,
    output ready
  );
endinterface

// File: sv/vfwf_mac.sv
// Three-lane multiply-accumulate unit with floor scaling and saturation
module vfwf_mac
  import vfwf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
  parameter int MAX_TAPS     = DEF_MAX_TAPS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vfwf_mac_ctl_t                  ctl,
  input  logic [AXES*SAMPLE_WIDTH-1:0]   smp,
  input  logic signed [COEF_WIDTH-1:0]   coef,
  output logic                           busy,
  output logic [AXES*SAMPLE_WIDTH-1:0]   res,
  output logic                           sat
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
  localparam int SHIFT  = COEF_WIDTH - 1;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic signed [PROD_W-1:0] prod_r [AXES];
  logic signed [ACC_W-1:0]  acc_r  [AXES];
  logic                     prod_v_r;
  logic [AXES-1:0]          clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (ctl.clear) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (ctl.en) begin
        prod_r[a] <= signed'(smp[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]) * coef;
      end
      if (ctl.clear) begin
        acc_r[a] <= '0;
      end else if (prod_v_r) begin
        acc_r[a] <= acc_r[a] + ACC_W'(prod_r[a]);
      end
    end
  end

  // arithmetic shift gives the floor of the scaled sum
  for (genvar g = 0; g < AXES; g++) begin : g_scale
    logic signed [ACC_W-1:0] scaled;
    always_comb begin
      scaled  = acc_r[g] >>> SHIFT;
      clip[g] = 1'b0;
      if (scaled > SAT_HI) begin
        res[g*SAMPLE_WIDTH +: SAMPLE_WIDTH] = SAT_HI[SAMPLE_WIDTH-1:0];
        clip[g] = 1'b1;
      end else if (scaled < SAT_LO) begin
        res[g*SAMPLE_WIDTH +: SAMPLE_WIDTH] = SAT_LO[SAMPLE_WIDTH-1:0];
        clip[g] = 1'b1;
      end else begin
        res[g*SAMPLE_WIDTH +: SAMPLE_WIDTH] = scaled[SAMPLE_WIDTH-1:0];
      end
    end
  end

  assign sat  = |clip;
  assign busy = prod_v_r;

endmodule

// File: sv/vector_fir_window_filter_core.sv
// Top level of the three-axis FIR window filter over a circular sample history
//
//  channel  | direction | handshake       | carries
//  ---------+-----------+-----------------+-----------------------------------------
//  in_chan  | in        | valid / ready   | command, sample x/y/z, tap_index, coef
//  out_chan | out       | valid / ready   | filt x/y/z, saturated
//  cfg_*    | in        | write enable    | tap_count (no read-back)
//
// A filter request runs from its accepting cycle through the MAC, drain and final
// states: one multiply-accumulate per tap through the single three-lane MAC unit,
// fed by the one read port of the history ring, then a drain of the read, product
// and accumulate stages and one final stage. Ready is low from MAC through FIN.
// A load request is done in its accepting cycle; a clear request sweeps taps entries.
// After reset the ring is zeroed by a pass over MAX_TAPS entries with ready low.
// A finished result waits in the output register; a new request is taken
// meanwhile, and only the final stage of the next filter request holds for it.
module vector_fir_window_filter_core
  import vfwf_pkg::*;
#(
  parameter int MAX_TAPS     = DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  vfwf_in_if.sink           in_chan,
  vfwf_out_if.source        out_chan,
  input  logic              cfg_wr_en,
  input  logic [TAPC_W-1:0] cfg_wr_data
);

  localparam int IDX_W  = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int TCW_W  = TAPC_W + CNT_W;
  localparam int TIW_W  = TIDX_W + IDX_W;
  localparam int SMP3_W = AXES * SAMPLE_WIDTH;

  // sequencer codes
  localparam logic [2:0] ST_CLEAR = 3'd0;  // zero ring entries, one a cycle
  localparam logic [2:0] ST_IDLE  = 3'd1;  // take a request
  localparam logic [2:0] ST_MAC   = 3'd2;  // issue one tap read a cycle
  localparam logic [2:0] ST_DRAIN = 3'd3;  // let the read and product stages empty
  localparam logic [2:0] ST_FIN   = 3'd4;  // hand the scaled sums to the output register

  logic [2:0]              state_r, state_nxt;
  logic [TAPC_W-1:0]       tap_count_r;
  logic [IDX_W-1:0]        wp_r;
  logic [CNT_W-1:0]        clr_cnt_r, clr_end_r;
  logic [IDX_W-1:0]        slot_r, cidx_r;
  logic [CNT_W-1:0]        left_r;
  logic                    rd_v_r;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_x_r, out_y_r, out_z_r;
  logic                    out_sat_r;

  logic [SMP3_W-1:0]             ring_mem [MAX_TAPS];
  logic [COEF_WIDTH-1:0]         coef_mem [MAX_TAPS];
  logic [SMP3_W-1:0]             ring_rd_r;
  logic [COEF_WIDTH-1:0]         coef_rd_r;

  logic [CNT_W-1:0]   taps, taps_m1_w, wp_inc;
  logic [IDX_W-1:0]   taps_m1, wp_eff, wp_next;
  logic [TCW_W-1:0]   tc_wide;
  logic [TIW_W-1:0]   tidx_wide;
  logic               in_acc, acc_filter, acc_load, acc_clear, tidx_ok;
  logic               clr_last, fin_go;
  logic               ring_we, coef_we;
  logic [IDX_W-1:0]   ring_wa;
  logic [SMP3_W-1:0]  ring_wd;

  vfwf_mac_ctl_t      mac_ctl;
  logic               mac_busy;
  logic [SMP3_W-1:0]  mac_res;
  logic               mac_sat;

  // active taps: zero counts as one, anything above the ring size clips to it
  always_comb begin
    tc_wide = {{CNT_W{1'b0}}, tap_count_r};
    if (tap_count_r == '0) begin
      taps = CNT_W'(1);
    end else if (tc_wide > TCW_W'(MAX_TAPS)) begin
      taps = CNT_W'(MAX_TAPS);
    end else begin
      taps = tc_wide[CNT_W-1:0];
    end
  end

  assign taps_m1_w = taps - CNT_W'(1);
  assign taps_m1   = taps_m1_w[IDX_W-1:0];

  // a write position left beyond a lowered tap count restarts at zero
  assign wp_eff  = (CNT_W'(wp_r) >= taps) ? '0 : wp_r;
  assign wp_inc  = CNT_W'(wp_eff) + CNT_W'(1);
  assign wp_next = (wp_inc >= taps) ? '0 : wp_inc[IDX_W-1:0];

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign acc_filter    = in_acc && (in_chan.command == CMD_FILTER);
  assign acc_load      = in_acc && (in_chan.command == CMD_LOAD);
  assign acc_clear     = in_acc && (in_chan.command == CMD_CLEAR);

  // load requests beyond the table are dropped
  assign tidx_wide = {{IDX_W{1'b0}}, in_chan.tap_index};
  assign tidx_ok   = (int'(in_chan.tap_index) < MAX_TAPS);

  assign clr_last = ((clr_cnt_r + CNT_W'(1)) == clr_end_r);
  assign fin_go   = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc_filter) begin
          state_nxt = ST_MAC;
        end else if (acc_clear) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_MAC: begin
        if (left_r == CNT_W'(1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v_r && !mac_busy) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      tap_count_r <= TAP_COUNT_RST;
      wp_r        <= '0;
      clr_cnt_r   <= '0;
      clr_end_r   <= CNT_W'(MAX_TAPS);
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == ST_MAC);
      if (cfg_wr_en) tap_count_r <= cfg_wr_data;
      if (acc_filter) wp_r <= wp_next;
      if (acc_clear) begin
        clr_cnt_r <= '0;
        clr_end_r <= taps;
      end else if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + CNT_W'(1);
      end
      if (state_r == ST_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // tap walk: ring backwards from the new sample, coefficients from the top
  always_ff @(posedge clk) begin
    if (acc_filter) begin
      slot_r <= wp_eff;
      cidx_r <= taps_m1;
      left_r <= taps;
    end else if (state_r == ST_MAC) begin
      slot_r <= (slot_r == '0) ? taps_m1 : slot_r - IDX_W'(1);
      cidx_r <= cidx_r - IDX_W'(1);
      left_r <= left_r - CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && fin_go) begin
      out_x_r   <= mac_res[0*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      out_y_r   <= mac_res[1*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      out_z_r   <= mac_res[2*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      out_sat_r <= mac_sat;
    end
  end

  // history ring: the sweep writes zeros, a filter request writes its sample
  assign ring_we = (state_r == ST_CLEAR) || acc_filter;
  assign ring_wa = (state_r == ST_CLEAR) ? clr_cnt_r[IDX_W-1:0] : wp_eff;
  assign ring_wd = (state_r == ST_CLEAR) ? '0 :
                   {in_chan.sample_z, in_chan.sample_y, in_chan.sample_x};
  assign coef_we = acc_load && tidx_ok;

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    ring_rd_r <= ring_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[tidx_wide[IDX_W-1:0]] <= in_chan.coef_value;
    coef_rd_r <= coef_mem[cidx_r];
  end

  assign mac_ctl.clear = acc_filter;
  assign mac_ctl.en    = rd_v_r;

  vfwf_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .MAX_TAPS     (MAX_TAPS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .smp   (ring_rd_r),
    .coef  (signed'(coef_rd_r)),
    .busy  (mac_busy),
    .res   (mac_res),
    .sat   (mac_sat)
  );

  assign out_chan.valid     = out_valid_r;
  assign out_chan.filt_x    = out_x_r;
  assign out_chan.filt_y    = out_y_r;
  assign out_chan.filt_z    = out_z_r;
  assign out_chan.saturated = out_sat_r;

endmodule

// File: sv/vfwf_checker.sv
// Port-level checks of the FIR window filter core, bound to the top level
`include "vector_fir_window_filter_core_macros.svh"

module vfwf_checker
  import vfwf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [CMD_W-1:0]        in_command,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] filt_x,
  input logic [SAMPLE_WIDTH-1:0] filt_y,
  input logic [SAMPLE_WIDTH-1:0] filt_z,
  input logic                    saturated
);

  localparam logic [SAMPLE_WIDTH-1:0] RAIL_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] RAIL_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // hold a result until it is taken
  `VFWF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a filter request always occupies the MAC sequencer
  `VFWF_ASSERT_NEXT(a_busy_after_filter, in_valid && in_ready && in_command == CMD_FILTER, !in_ready, "ready held after filter request")

  // a clipped result sits on a rail in at least one axis
  `VFWF_ASSERT_NOW(a_sat_on_rail, out_valid && saturated, filt_x == RAIL_HI || filt_x == RAIL_LO || filt_y == RAIL_HI || filt_y == RAIL_LO || filt_z == RAIL_HI || filt_z == RAIL_LO, "saturated flag without a rail value")

endmodule

bind vector_fir_window_filter_core vfwf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_vfwf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_command (in_chan.command),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .filt_x     (out_chan.filt_x),
  .filt_y     (out_chan.filt_y),
  .filt_z     (out_chan.filt_z),
  .saturated  (out_chan.saturated)
);
